FILE: design/nfvn_pkg.sv
// Package for the normalised fractal value noise block: fixed-point types,
// hash and octave constants, and the request bundle handed to each evaluator.
// No dependencies.
`default_nettype none
package nfvn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    typedef logic [16:0] q_t;    // unsigned Q1.16, 0..ONE
    typedef logic [15:0] lvl_t;  // unsigned Q0.16 lattice level

    localparam logic [31:0] MIX_C1     = 32'h7feb352d;
    localparam logic [31:0] MIX_C2     = 32'h846ca68b;
    localparam logic [31:0] CHAN_K     = 32'h9e3779b9;
    localparam logic [31:0] PT_K       = 32'h85ebca6b;
    localparam logic [31:0] SEED_OFS_B = 32'h68bc21eb;
    localparam logic [31:0] SEED_OFS_C = 32'h02e5be93;

    localparam logic [19:0] FREQ_A   = 20'(3 * ONE);
    localparam logic [19:0] FREQ_B   = 20'((651 * ONE + 50) / 100);
    localparam logic [19:0] FREQ_C   = 20'((1413 * ONE + 50) / 100);
    localparam logic [15:0] WEIGHT_A = 16'((58 * ONE + 50) / 100);
    localparam logic [15:0] WEIGHT_B = 16'((29 * ONE + 50) / 100);
    localparam logic [15:0] WEIGHT_C = 16'((13 * ONE + 50) / 100);

    localparam logic [2:0][19:0] FREQ   = {FREQ_C, FREQ_B, FREQ_A};
    localparam logic [2:0][15:0] WEIGHT = {WEIGHT_C, WEIGHT_B, WEIGHT_A};

    localparam logic [19:0] FADE_15 = 20'(15 * ONE);
    localparam logic [19:0] FADE_10 = 20'(10 * ONE);
    localparam q_t          Q_ONE   = 17'(ONE);
    localparam q_t          Q_HALF  = 17'(ONE / 2);

    // Per-item request; all evaluators share its seeds and channel mix, sample evaluators substitute their own position
    typedef struct packed {
        logic [31:0] seed_a;
        logic [31:0] seed_b;
        logic [31:0] seed_c;
        logic [31:0] chan_mix;
        q_t          pos;
    } nfvn_req_t;

endpackage
`default_nettype wire

FILE: design/nfvn_eval.sv
// Eight-stage pipelined evaluator of three-octave value noise at one position.
// Depends on nfvn_pkg.
`default_nettype none
module nfvn_eval
    import nfvn_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      en,
    input  wire nfvn_req_t req,
    output q_t             noise
);

    logic [20:0] x_reg    [3];
    logic [31:0] seed_reg [3];
    logic [31:0] chan_reg;
    logic [31:0] va0_reg [3], va1_reg [3];
    logic [31:0] vb0_reg [3], vb1_reg [3];
    logic [31:0] vc0_reg [3], vc1_reg [3];
    logic [15:0] t2_reg [3], t3_reg [3], tt_reg [3];
    logic [19:0] tq_reg [3], poly_reg [3], b_reg [3];
    logic [32:0] p0_reg [3], p1_reg [3];
    lvl_t        oct_reg [3];
    logic [31:0] wp_reg [3];
    q_t          noise_reg;

    always_ff @(posedge aclk) begin
        if (en) chan_reg <= req.chan_mix;
    end

    for (genvar o = 0; o < 3; o++) begin : g_oct
        logic [36:0] xp;
        logic [4:0]  left;
        logic [15:0] t;
        logic [31:0] pm0, pm1, h0, h1;
        logic [31:0] t_sq;
        logic [19:0] q;
        logic [35:0] tqp;
        logic [31:0] t3p;
        logic [35:0] bp;
        logic [31:0] vb0x, vb1x, vc0x, vc1x;
        q_t          f;
        lvl_t        lat0, lat1;
        logic [33:0] isum;

        always_comb begin
            xp   = 37'(req.pos) * 37'(FREQ[o]);
            left = x_reg[o][20:16];
            t    = x_reg[o][15:0];
            pm0  = {27'd0, left} * PT_K;
            pm1  = ({27'd0, left} + 32'd1) * PT_K;
            h0   = seed_reg[o] ^ chan_reg ^ pm0;
            h1   = seed_reg[o] ^ chan_reg ^ pm1;
            t_sq = 32'(t) * 32'(t);
            q    = FADE_15 - 20'(6 * 20'(t));
            tqp  = 36'(t) * 36'(q);
            t3p  = 32'(tt_reg[o]) * 32'(t2_reg[o]);
            bp   = 36'(t3_reg[o]) * 36'(poly_reg[o]);
            vb0x = vb0_reg[o] ^ (vb0_reg[o] >> 15);
            vb1x = vb1_reg[o] ^ (vb1_reg[o] >> 15);
            vc0x = vc0_reg[o] ^ (vc0_reg[o] >> 16);
            vc1x = vc1_reg[o] ^ (vc1_reg[o] >> 16);
            lat0 = vc0x[31:16];
            lat1 = vc1x[31:16];
            f    = (b_reg[o] > 20'(ONE)) ? Q_ONE : b_reg[o][16:0];
            isum = 34'(p0_reg[o]) + 34'(p1_reg[o]);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                // E1: scale position by octave frequency
                x_reg[o]    <= xp[36:16];
                seed_reg[o] <= (o == 0) ? req.seed_a : ((o == 1) ? req.seed_b : req.seed_c);
                // E2: hash pre-mix and fade first products
                va0_reg[o]  <= h0 ^ (h0 >> 16);
                va1_reg[o]  <= h1 ^ (h1 >> 16);
                tt_reg[o]   <= t_sq[31:16];
                t2_reg[o]   <= t;
                tq_reg[o]   <= tqp[35:16];
                // E3
                vb0_reg[o]  <= va0_reg[o] * MIX_C1;
                vb1_reg[o]  <= va1_reg[o] * MIX_C1;
                t3_reg[o]   <= t3p[31:16];
                poly_reg[o] <= FADE_10 - tq_reg[o];
                // E4
                vc0_reg[o]  <= vb0x * MIX_C2;
                vc1_reg[o]  <= vb1x * MIX_C2;
                b_reg[o]    <= bp[35:16];
                // E5: blend products
                p0_reg[o]   <= 33'(lat0) * 33'(Q_ONE - f);
                p1_reg[o]   <= 33'(lat1) * 33'(f);
                // E6
                oct_reg[o]  <= isum[31:16];
                // E7: octave weight
                wp_reg[o]   <= 32'(oct_reg[o]) * 32'(WEIGHT[o]);
            end
        end
    end

    logic [33:0] wsum;
    assign wsum = 34'(wp_reg[0]) + 34'(wp_reg[1]) + 34'(wp_reg[2]);

    // E8: weighted sum, clamp to one
    always_ff @(posedge aclk) begin
        if (en) noise_reg <= (wsum[33:16] > 18'(ONE)) ? Q_ONE : wsum[32:16];
    end

    assign noise = noise_reg;

endmodule
`default_nettype wire

FILE: design/normalized_fractal_value_noise_top.sv
// Top level of the normalised fractal value noise block: input register,
// evaluator bank, min/max tree, pipelined divider. Depends on nfvn_pkg, nfvn_eval.
`default_nettype none
// Usage
//   Slave channel s_*: one beat carries seed, channel index and position.
//   Master channel m_*: one beat carries the normalised noise value.
//   Every beat yields exactly one result beat, in order.
// Throughput: one beat per cycle. Every stage holds at most one item and the
//   whole pipeline advances together, so a new beat enters in every cycle in
//   which the output register is empty or being taken.
// Pipeline: from acceptance to m_tvalid a beat passes the input register, the noise
//   evaluators, the min/max tree, the normalisation set-up, the restoring
//   divider (one quotient bit per stage) and the output register.
// Resources: NUM_SAMPLES+2 evaluators run side by side, one per sample point
//   and one for the requested position.
// Reset: aresetn low clears every valid bit; no beat is presented after reset
//   until a new one is accepted. Payload registers are not reset.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds,
//   s_tready drops, and nothing is lost or repeated.
module normalized_fractal_value_noise_top
    import nfvn_pkg::*;
#(
    parameter int NUM_SAMPLES = 33
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // [31:0] seed, [63:32] parameter_index,
                                        // [80:64] position, rest zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [16:0] noise_value, rest zero
);

    localparam int NPTS  = NUM_SAMPLES + 1;
    localparam int G1    = (NPTS + 7) / 8;
    localparam int G2    = (G1 + 7) / 8;
    localparam int DIV_W = FRAC_BITS;
    localparam int S_TREE = 11;              // stage index of last tree level
    localparam int S_NORM = S_TREE + 1;
    localparam int LAT    = S_NORM + DIV_W + 2;

    logic           en;
    logic [LAT-1:0] vld_reg;

    // Whole pipeline advances when the output register is free
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Input register: derive octave seeds and channel mix, saturate position
    nfvn_req_t   req_reg;
    logic [31:0] in_seed, in_chan;
    q_t          in_pos;

    assign in_seed = s_tdata[31:0];
    assign in_chan = s_tdata[63:32];
    assign in_pos  = s_tdata[80:64];

    always_ff @(posedge aclk) begin
        if (en) begin
            req_reg.seed_a   <= in_seed;
            req_reg.seed_b   <= in_seed + SEED_OFS_B;
            req_reg.seed_c   <= in_seed + SEED_OFS_C;
            req_reg.chan_mix <= in_chan * CHAN_K;
            req_reg.pos      <= (in_pos > Q_ONE) ? Q_ONE : in_pos;
        end
    end

    // Evaluator bank: fixed sample points plus the requested position
    q_t samp   [NPTS];
    q_t lo_pad [G1*8];
    q_t hi_pad [G1*8];
    q_t raw;

    for (genvar k = 0; k < NPTS; k++) begin : g_samp
        localparam q_t SP = 17'((k * ONE) / NUM_SAMPLES);
        nfvn_req_t sreq;
        always_comb begin
            sreq     = req_reg;
            sreq.pos = SP;
        end
        nfvn_eval u_eval (.aclk(aclk), .en(en), .req(sreq), .noise(samp[k]));
    end

    nfvn_eval u_eval_pos (.aclk(aclk), .en(en), .req(req_reg), .noise(raw));

    for (genvar k = 0; k < G1*8; k++) begin : g_pad1
        if (k < NPTS) begin : g_real
            assign lo_pad[k] = samp[k];
            assign hi_pad[k] = samp[k];
        end else begin : g_fill
            assign lo_pad[k] = Q_ONE;
            assign hi_pad[k] = '0;
        end
    end

    // Tree level 1: groups of eight
    q_t lo1_reg [G1], hi1_reg [G1];
    q_t lo1_pad [G2*8], hi1_pad [G2*8];
    q_t raw1_reg, raw2_reg, raw3_reg;

    for (genvar g = 0; g < G1; g++) begin : g_lvl1
        q_t mn, mx;
        always_comb begin
            mn = lo_pad[g*8];
            mx = hi_pad[g*8];
            for (int j = 1; j < 8; j++) begin
                if (lo_pad[g*8+j] < mn) mn = lo_pad[g*8+j];
                if (hi_pad[g*8+j] > mx) mx = hi_pad[g*8+j];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                lo1_reg[g] <= mn;
                hi1_reg[g] <= mx;
            end
        end
    end

    for (genvar k = 0; k < G2*8; k++) begin : g_pad2
        if (k < G1) begin : g_real
            assign lo1_pad[k] = lo1_reg[k];
            assign hi1_pad[k] = hi1_reg[k];
        end else begin : g_fill
            assign lo1_pad[k] = Q_ONE;
            assign hi1_pad[k] = '0;
        end
    end

    // Tree level 2
    q_t lo2_reg [G2], hi2_reg [G2];

    for (genvar g = 0; g < G2; g++) begin : g_lvl2
        q_t mn, mx;
        always_comb begin
            mn = lo1_pad[g*8];
            mx = hi1_pad[g*8];
            for (int j = 1; j < 8; j++) begin
                if (lo1_pad[g*8+j] < mn) mn = lo1_pad[g*8+j];
                if (hi1_pad[g*8+j] > mx) mx = hi1_pad[g*8+j];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                lo2_reg[g] <= mn;
                hi2_reg[g] <= mx;
            end
        end
    end

    // Tree level 3
    q_t lo3_reg, hi3_reg, mn3, mx3;

    always_comb begin
        mn3 = lo2_reg[0];
        mx3 = hi2_reg[0];
        for (int j = 1; j < G2; j++) begin
            if (lo2_reg[j] < mn3) mn3 = lo2_reg[j];
            if (hi2_reg[j] > mx3) mx3 = hi2_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo3_reg  <= mn3;
            hi3_reg  <= mx3;
            raw1_reg <= raw;
            raw2_reg <= raw1_reg;
            raw3_reg <= raw2_reg;
        end
    end

    // Normalisation set-up and restoring divider, one quotient bit per stage
    logic [17:0]       dv_r    [DIV_W+1];
    q_t                dv_d    [DIV_W+1];
    logic [DIV_W-1:0]  dv_q    [DIV_W+1];
    logic              dv_flat [DIV_W+1];
    logic              dv_under[DIV_W+1];
    logic              dv_over [DIV_W+1];
    q_t                nrm_n, nrm_d;

    assign nrm_n = raw3_reg - lo3_reg;
    assign nrm_d = hi3_reg - lo3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_r[0]     <= {1'b0, nrm_n};
            dv_d[0]     <= nrm_d;
            dv_q[0]     <= '0;
            dv_flat[0]  <= hi3_reg <= lo3_reg;
            dv_under[0] <= raw3_reg <= lo3_reg;
            dv_over[0]  <= nrm_n >= nrm_d;
        end
    end

    for (genvar i = 0; i < DIV_W; i++) begin : g_div
        logic [17:0] r2;
        logic        take;
        assign r2   = {dv_r[i][16:0], 1'b0};
        assign take = r2 >= {1'b0, dv_d[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_r[i+1]     <= take ? (r2 - {1'b0, dv_d[i]}) : r2;
                dv_q[i+1]     <= {dv_q[i][DIV_W-2:0], take};
                dv_d[i+1]     <= dv_d[i];
                dv_flat[i+1]  <= dv_flat[i];
                dv_under[i+1] <= dv_under[i];
                dv_over[i+1]  <= dv_over[i];
            end
        end
    end

    // Output register: select flat, below-minimum, above-maximum or quotient
    q_t res_reg, res_next;

    always_comb begin
        if (dv_flat[DIV_W])       res_next = Q_HALF;
        else if (dv_under[DIV_W]) res_next = '0;
        else if (dv_over[DIV_W])  res_next = Q_ONE;
        else                      res_next = {1'b0, dv_q[DIV_W]};
    end

    always_ff @(posedge aclk) begin
        if (en) res_reg <= res_next;
    end

    assign m_tdata = {7'd0, res_reg};

    // Checks
    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && s_tvalid) |=> vld_reg[0])
        else $error("accepted beat not captured");

    a_tree_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_TREE] |-> (lo3_reg <= hi3_reg))
        else $error("minimum above maximum");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAT-2] && !dv_flat[DIV_W] && !dv_under[DIV_W] && !dv_over[DIV_W])
        |-> (dv_r[DIV_W] < {1'b0, dv_d[DIV_W]}))
        else $error("divider remainder not below divisor");

    a_flat_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAT-2] && dv_flat[DIV_W] && en) |=> (m_tdata[16:0] == Q_HALF))
        else $error("flat field not mapped to one half");

endmodule
`default_nettype wire

FILE: tb/sv/nfvn_checker.sv
// Scoreboard for the normalised fractal value noise block: watches both stream
// channels, predicts each noise value in fixed point and compares in order.
// Depends on nfvn_pkg for the hash, frequency and weight constants.
module nfvn_checker
    import nfvn_pkg::*;
#(
    parameter int NUM_SAMPLES = 33
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    output int               fail_count,
    output int               pending,
    output int               checked
);

    logic [16:0] noise_q[$];

    function automatic logic [63:0] lattice_level(logic [31:0] sd, logic [31:0] ch,
                                                  logic [31:0] pt);
        logic [31:0] v;
        v = sd ^ (ch * CHAN_K) ^ (pt * PT_K);
        v = v ^ (v >> 16);
        v = v * MIX_C1;
        v = v ^ (v >> 15);
        v = v * MIX_C2;
        v = v ^ (v >> 16);
        return 64'(v >> 16);
    endfunction

    function automatic logic [63:0] quintic(logic [63:0] t);
        logic [63:0] t3, q, poly, b;
        t3   = (((t * t) >> 16) * t) >> 16;
        q    = 64'(FADE_15) - 6 * t;
        poly = 64'(FADE_10) - ((t * q) >> 16);
        b    = (t3 * poly) >> 16;
        return (b > ONE) ? 64'(ONE) : b;
    endfunction

    function automatic logic [63:0] octave_level(logic [31:0] sd, logic [31:0] ch,
                                                 logic [63:0] pos, logic [63:0] freq);
        logic [63:0] x, f, v0, v1;
        logic [31:0] left;
        x    = (pos * freq) >> 16;
        left = 32'(x >> 16);
        f    = quintic(x & 64'hffff);
        v0   = lattice_level(sd, ch, left);
        v1   = lattice_level(sd, ch, left + 1);
        return (v0 * (ONE - f) + v1 * f) >> 16;
    endfunction

    function automatic logic [63:0] fractal_sum(logic [31:0] sd, logic [31:0] ch,
                                                logic [63:0] pos);
        logic [63:0] a, b, c, s;
        a = octave_level(sd, ch, pos, 64'(FREQ_A));
        b = octave_level(sd + SEED_OFS_B, ch, pos, 64'(FREQ_B));
        c = octave_level(sd + SEED_OFS_C, ch, pos, 64'(FREQ_C));
        s = (a * WEIGHT_A + b * WEIGHT_B + c * WEIGHT_C) >> 16;
        return (s > ONE) ? 64'(ONE) : s;
    endfunction

    function automatic logic [16:0] normalised_noise(logic [87:0] beat);
        logic [31:0] sd, ch;
        logic [63:0] p, lo, hi, v, raw, res;
        sd = beat[31:0];
        ch = beat[63:32];
        p  = 64'(beat[80:64]);
        lo = ONE;
        hi = 0;
        if (p > ONE) p = ONE;
        for (int k = 0; k <= NUM_SAMPLES; k++) begin
            v = fractal_sum(sd, ch, (64'(k) * ONE) / NUM_SAMPLES);
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        if (hi <= lo) begin
            res = ONE / 2;
        end else begin
            raw = fractal_sum(sd, ch, p);
            if (raw <= lo) begin
                res = 0;
            end else begin
                res = ((raw - lo) * ONE) / (hi - lo);
                if (res > ONE) res = ONE;
            end
        end
        return res[16:0];
    endfunction

    initial begin
        fail_count = 0;
        checked    = 0;
    end

    assign pending = noise_q.size();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) noise_q.push_back(normalised_noise(s_tdata));
            if (m_tvalid && m_tready) begin
                if (noise_q.size() == 0) begin
                    $error("unexpected result beat: noise_value actual %0d", m_tdata[16:0]);
                    fail_count++;
                end else begin
                    logic [16:0] want;
                    want = noise_q.pop_front();
                    checked <= checked + 1;
                    if (m_tdata[16:0] !== want) begin
                        $error("noise_value mismatch: expected %0d actual %0d",
                               want, m_tdata[16:0]);
                        fail_count++;
                    end
                    if (m_tdata[23:17] !== 7'd0) begin
                        $error("padding mismatch: expected 0 actual %0h", m_tdata[23:17]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/normalized_fractal_value_noise_top_tb.sv
// Stimulus and verdict for the normalised fractal value noise block.
// Depends on nfvn_pkg, normalized_fractal_value_noise_top and nfvn_checker.
module normalized_fractal_value_noise_top_tb;
    import nfvn_pkg::*;

    localparam int LATENCY     = 30;
    localparam int RANDOM_BEATS = 1550;
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    int          fail_count, pending, checked;
    int          cycle_count = 0;
    int          sent = 0;
    bit          stall_on = 1'b1;

    always #5 aclk = ~aclk;

    normalized_fractal_value_noise_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    nfvn_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    // Pack one beat: seed lowest, then channel index, then position.
    function automatic logic [87:0] pack_beat(logic [31:0] sd, logic [31:0] ch,
                                              logic [16:0] pos);
        return {7'd0, pos, ch, sd};
    endfunction

    // Random position: mostly in range, sometimes at the ends or saturating.
    function automatic logic [16:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return 17'(ONE);
            1:       return 17'($urandom_range(ONE + 1, 17'h1ffff));
            2:       return 17'($urandom_range(0, 3));
            default: return 17'($urandom_range(0, ONE));
        endcase
    endfunction

    // Present one beat and hold it until taken; gaps come from the burst logic.
    // Sample ready mid-cycle, where it already shows the value at the next edge.
    task automatic send_beat(logic [87:0] beat);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        sent++;
    endtask

    // After a burst, sometimes drop valid and idle for a random gap.
    task automatic burst_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver stall pattern: alternate stalling and free-running stretches.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
        m_tready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // Cap the run.
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [31:0] sd, ch;
        int burst;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes and position edge cases.
        send_beat(pack_beat(32'h0, 32'h0, 17'd0));
        send_beat(pack_beat(32'h0, 32'h0, 17'(ONE)));
        send_beat(pack_beat(32'hffffffff, 32'hffffffff, 17'h1ffff));
        send_beat(pack_beat(32'hffffffff, 32'h0, 17'(ONE + 1)));
        send_beat(pack_beat(32'h0, 32'hffffffff, 17'(ONE / 2)));
        send_beat(pack_beat(32'h12345678, 32'd1, 17'(ONE - 1)));
        send_beat(pack_beat(32'h12345678, 32'd2, 17'd1));
        send_beat(pack_beat(32'haaaaaaaa, 32'h55555555, 17'h0aaaa));
        send_beat(pack_beat(32'h55555555, 32'haaaaaaaa, 17'h15555));
        send_beat(pack_beat(-SEED_OFS_B, 32'd7, 17'(ONE / 3)));
        send_beat(pack_beat(-SEED_OFS_C, 32'd7, 17'(2 * ONE / 3)));
        // Positions exactly on sample points 0, 11, 22 and 33.
        for (int k = 0; k <= 33; k += 11)
            send_beat(pack_beat(32'hdeadbeef, 32'd3, 17'((k * ONE) / 33)));
        burst_gap();

        // Random: bursts of random length, mixed seeds and channels.
        while (sent < RANDOM_BEATS + 15) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                sd = $urandom();
                ch = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom();
                send_beat(pack_beat(sd, ch, pick_position()));
            end
            burst_gap();
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expectation, then let the pipeline settle.
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        $display("Covered %0d beats (%0d results checked) with saturating positions,",
                 sent, checked);
        $display("extreme seeds and channels, and random stalls on both channels.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
